>>> design/pae_pkg.sv
package pae_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int SLOT_W = 6;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_UPDATE  = 2'd1,
        CMD_DELETE  = 2'd2,
        CMD_DISPLAY = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_UPDATE,
        OP_DELETE,
        OP_ROTATE
    } cell_op_t;

    // Broadcast to every cell; indexes are 0-based.
    typedef struct packed {
        cell_op_t         op;
        logic [POS_W-1:0] pos0;
        logic [POS_W-1:0] tail;
    } cell_ctl_t;

endpackage

>>> design/pae_cell.sv
module pae_cell #(
    parameter int IDX = 0
) (
    input  logic                       clk,
    input  pae_pkg::cell_ctl_t         ctl,
    input  logic [pae_pkg::DATA_W-1:0] data_in,
    input  logic [pae_pkg::DATA_W-1:0] left,
    input  logic [pae_pkg::DATA_W-1:0] right,
    input  logic [pae_pkg::DATA_W-1:0] head,
    output logic [pae_pkg::DATA_W-1:0] q
);
    import pae_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic [DATA_W-1:0] elem_reg;
    logic [DATA_W-1:0] elem_next;

    always_comb
    begin
        elem_next = elem_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (MY_IDX == ctl.pos0)
                    elem_next = data_in;
                else if (MY_IDX > ctl.pos0)
                    elem_next = left;
            end
            OP_UPDATE:
            begin
                if (MY_IDX == ctl.pos0)
                    elem_next = data_in;
            end
            OP_DELETE:
            begin
                if (MY_IDX >= ctl.pos0)
                    elem_next = right;
            end
            OP_ROTATE:
            begin
                // ring over the held entries: the tail takes the head's value
                if (MY_IDX == ctl.tail)
                    elem_next = head;
                else if (MY_IDX < ctl.tail)
                    elem_next = right;
            end
            default:
            begin
                elem_next = elem_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
    end

    assign q = elem_reg;

endmodule

>>> design/positional_array_editor.sv
// Edit commands (insert, update, delete) and a display of an empty list: one result beat,
// registered at accept. Other displays enter the display state, which loads the first beat
// and then one beat per cycle while the output register can take one, for count entries;
// the cell row rotates one place per beat and ends in its original order. One item at a
// time; the next is taken once the previous one's last beat is registered and the output
// register can take a new beat. Reset clears the entry count, the control state and the
// output register; cell contents are not reset and are only read after being written.
module positional_array_editor #(
    parameter int DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        cmd,
    input  logic [pae_pkg::POS_W-1:0]         position,
    input  logic signed [pae_pkg::DATA_W-1:0] data_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic signed [pae_pkg::DATA_W-1:0] data_out,
    output logic [pae_pkg::SLOT_W-1:0]        slot,
    output logic                              last
);
    import pae_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic {
        S_IDLE,
        S_DISP
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     count_reg;
    logic [IW-1:0]     beat_reg;
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [DATA_W-1:0] data_out_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              last_reg;

    logic              out_free;
    logic              in_fire;
    logic              disp_step;
    logic              out_load;
    logic [POS_W:0]    pos_ext;
    logic [POS_W:0]    cnt_ext;
    logic              ins_pos_ok;
    logic              ed_pos_ok;
    logic              is_full;
    logic [POS_W-1:0]  tail;
    logic              disp_last;
    cell_ctl_t         ctl;
    status_t           edit_status;
    logic [DATA_W-1:0] cell_q [DEPTH];

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign in_fire   = in_valid && in_ready;
    assign disp_step = (state_reg == S_DISP) && out_free;
    // a non-empty display starts streaming on the next cycle instead of loading a beat now
    assign out_load  = (in_fire && !(cmd_t'(cmd) == CMD_DISPLAY && count_reg != '0))
                       || disp_step;

    assign pos_ext    = {1'b0, position};
    assign cnt_ext    = (POS_W + 1)'(count_reg);
    assign ins_pos_ok = (position != '0) && (pos_ext <= cnt_ext + 1'b1);
    assign ed_pos_ok  = (position != '0) && (pos_ext <= cnt_ext);
    assign is_full    = (count_reg == CW'(DEPTH));
    assign tail       = POS_W'(count_reg) - 1'b1;
    assign disp_last  = (POS_W'(beat_reg) == tail);

    always_comb
    begin
        ctl.op      = OP_HOLD;
        ctl.pos0    = position - 1'b1;
        ctl.tail    = tail;
        edit_status = ST_OK;
        if (disp_step)
        begin
            ctl.op = OP_ROTATE;
        end
        else if (in_fire)
        begin
            case (cmd_t'(cmd))
                CMD_INSERT:
                begin
                    if (!ins_pos_ok)
                        edit_status = ST_BADPOS;
                    else if (is_full)
                        edit_status = ST_FULL;
                    else
                        ctl.op = OP_INSERT;
                end
                CMD_UPDATE:
                begin
                    if (!ed_pos_ok)
                        edit_status = ST_BADPOS;
                    else
                        ctl.op = OP_UPDATE;
                end
                CMD_DELETE:
                begin
                    if (!ed_pos_ok)
                        edit_status = ST_BADPOS;
                    else
                        ctl.op = OP_DELETE;
                end
                CMD_DISPLAY:
                begin
                    edit_status = ST_EMPTY;
                end
                default:
                begin
                    edit_status = ST_OK;
                end
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        pae_cell #(
            .IDX (g)
        ) u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .data_in (data_in),
            .left    (cell_q[(g == 0) ? 0 : g - 1]),
            .right   (cell_q[(g == DEPTH - 1) ? g : g + 1]),
            .head    (cell_q[0]),
            .q       (cell_q[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            beat_reg      <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            data_out_reg  <= '0;
            slot_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        beat_reg <= '0;
                        if (cmd_t'(cmd) == CMD_DISPLAY && count_reg != '0)
                        begin
                            state_reg <= S_DISP;
                        end
                        else
                        begin
                            status_reg    <= edit_status;
                            data_out_reg  <= '0;
                            slot_reg      <= '0;
                            last_reg      <= 1'b1;
                            if (ctl.op == OP_INSERT)
                                count_reg <= count_reg + 1'b1;
                            else if (ctl.op == OP_DELETE)
                                count_reg <= count_reg - 1'b1;
                        end
                    end
                end
                S_DISP:
                begin
                    if (disp_step)
                    begin
                        status_reg    <= ST_OK;
                        data_out_reg  <= cell_q[0];
                        slot_reg      <= SLOT_W'(beat_reg);
                        last_reg      <= disp_last;
                        beat_reg      <= beat_reg + 1'b1;
                        if (disp_last)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data_out  = data_out_reg;
    assign slot      = slot_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_disp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DISP |-> count_reg != '0)
        else $error("display running on empty list");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.op == OP_INSERT |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow count");

    a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.op == OP_DELETE |=> count_reg == $past(count_reg) - 1'b1)
        else $error("delete did not shrink count");

    a_disp_end: assert property (@(posedge clk) disable iff (!rst_n)
        disp_step && disp_last |=> state_reg == S_IDLE && last_reg)
        else $error("display did not end on last beat");
`endif

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pae_pkg::*;

    localparam int DEPTH        = 32;
    localparam int RANDOM_ITEMS = 440;
    localparam int LIMIT_CYCLES = 500_000;

    typedef struct {
        status_t                    status;
        logic signed [DATA_W-1:0]   value;
        logic [SLOT_W-1:0]          slot;
        logic                       last;
    } list_beat_t;

    // Shadow copy of the list plus the beats each accepted command should produce.
    class list_tracker;
        logic signed [DATA_W-1:0] shadow_list[$];
        list_beat_t               pending_beats[$];
        int                       errors;

        function new();
            errors = 0;
        endfunction

        function int held();
            return shadow_list.size();
        endfunction

        function int pending();
            return pending_beats.size();
        endfunction

        function void push_status(status_t st);
            list_beat_t b;
            b.status = st;
            b.value  = '0;
            b.slot   = '0;
            b.last   = 1'b1;
            pending_beats.push_back(b);
        endfunction

        function void note_command(cmd_t c, logic [POS_W-1:0] pos,
                                   logic signed [DATA_W-1:0] val);
            int p;
            int n;
            list_beat_t b;
            p = pos;
            n = shadow_list.size();
            case (c)
                CMD_INSERT:
                begin
                    if (p < 1 || p > n + 1)
                        push_status(ST_BADPOS);
                    else if (n >= DEPTH)
                        push_status(ST_FULL);
                    else
                    begin
                        shadow_list.insert(p - 1, val);
                        push_status(ST_OK);
                    end
                end
                CMD_UPDATE:
                begin
                    if (p < 1 || p > n)
                        push_status(ST_BADPOS);
                    else
                    begin
                        shadow_list[p - 1] = val;
                        push_status(ST_OK);
                    end
                end
                CMD_DELETE:
                begin
                    if (p < 1 || p > n)
                        push_status(ST_BADPOS);
                    else
                    begin
                        shadow_list.delete(p - 1);
                        push_status(ST_OK);
                    end
                end
                default:
                begin
                    if (n == 0)
                        push_status(ST_EMPTY);
                    else
                        for (int i = 0; i < n; i++)
                        begin
                            b.status = ST_OK;
                            b.value  = shadow_list[i];
                            b.slot   = i[SLOT_W-1:0];
                            b.last   = (i == n - 1);
                            pending_beats.push_back(b);
                        end
                end
            endcase
        endfunction

        function void check_beat(logic [1:0] st, logic signed [DATA_W-1:0] value,
                                 logic [SLOT_W-1:0] sl, logic lst);
            list_beat_t b;
            if (pending_beats.size() == 0)
            begin
                $error("unexpected beat: status %0d data_out %0d slot %0d last %0b",
                       st, value, sl, lst);
                errors++;
                return;
            end
            b = pending_beats.pop_front();
            if (st !== b.status)
            begin
                $error("status: expected %0d, got %0d", b.status, st);
                errors++;
            end
            if (value !== b.value)
            begin
                $error("data_out: expected %0d, got %0d", b.value, value);
                errors++;
            end
            if (sl !== b.slot)
            begin
                $error("slot: expected %0d, got %0d", b.slot, sl);
                errors++;
            end
            if (lst !== b.last)
            begin
                $error("last: expected %0b, got %0b", b.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic [1:0]                cmd       = '0;
    logic [POS_W-1:0]          position  = '0;
    logic signed [DATA_W-1:0]  data_in   = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [1:0]                status;
    logic signed [DATA_W-1:0]  data_out;
    logic [SLOT_W-1:0]         slot;
    logic                      last;

    list_tracker tracker = new();
    int          burst_left;
    int          rx_cycle;
    int          rx_mode;
    int          cycles;

    positional_array_editor #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .position (position),
        .data_in  (data_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .data_out (data_out),
        .slot     (slot),
        .last     (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Receiver: check the beat taken at this edge, then pick the next ready value.
    // The stall mode is redrawn at random through the run, from always ready to mostly stalled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                tracker.check_beat(status, data_out, slot, last);
            if (rx_cycle % 50 == 0)
                rx_mode = $urandom_range(0, 3);
            rx_cycle++;
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (rx_cycle % 5 != 0);
            endcase
        end
    end

    task automatic send_command(input cmd_t c, input int pos,
                                input logic signed [DATA_W-1:0] val);
        in_valid <= 1'b1;
        cmd      <= c;
        position <= pos[POS_W-1:0];
        data_in  <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_command(c, pos[POS_W-1:0], val);
    endtask

    // Bursts of back-to-back commands with random gaps; some bursts are long.
    task automatic pace();
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic directed(input cmd_t c, input int pos,
                            input logic signed [DATA_W-1:0] val);
        send_command(c, pos, val);
        pace();
    endtask

    // Grow phases favor inserts so the list fills up; shrink phases favor deletes.
    task automatic random_command(input bit grow);
        int n;
        int r;
        int hi;
        int p;
        cmd_t c;
        n = tracker.held();
        r = $urandom_range(0, 99);
        if (r < 8)
            c = CMD_DISPLAY;
        else if (r < (grow ? 78 : 38))
            c = CMD_INSERT;
        else if (r < (grow ? 88 : 58))
            c = CMD_UPDATE;
        else
            c = CMD_DELETE;
        hi = (c == CMD_INSERT) ? n + 1 : n;
        if (hi == 0 || $urandom_range(0, 9) == 0)
            p = $urandom_range(0, 127);
        else
            p = $urandom_range(1, hi);
        send_command(c, p, $urandom());
    endtask

    initial
    begin
        bit grow;
        burst_left = $urandom_range(1, 8);
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, bad positions, both ends and the middle, extreme values
        directed(CMD_DISPLAY, 0, 32'sd0);
        directed(CMD_DELETE, 1, 32'sd0);
        directed(CMD_UPDATE, 1, 32'sd5);
        directed(CMD_INSERT, 0, 32'sd7);
        directed(CMD_INSERT, 2, 32'sd7);
        directed(CMD_INSERT, 1, 32'sh7FFF_FFFF);
        directed(CMD_INSERT, 1, 32'sh8000_0000);
        directed(CMD_INSERT, 3, -32'sd1);
        directed(CMD_INSERT, 2, 32'sd0);
        directed(CMD_INSERT, 127, 32'sd9);
        directed(CMD_UPDATE, 4, 32'sd12345);
        directed(CMD_UPDATE, 5, 32'sd1);
        directed(CMD_UPDATE, 0, 32'sd1);
        directed(CMD_DISPLAY, 127, 32'sd0);
        directed(CMD_DELETE, 2, 32'sd0);
        directed(CMD_DELETE, 3, 32'sd0);
        directed(CMD_DELETE, 0, 32'sd0);
        directed(CMD_DELETE, 127, 32'sd0);
        directed(CMD_DISPLAY, 0, 32'sd0);
        directed(CMD_DELETE, 1, 32'sd0);
        directed(CMD_DELETE, 1, 32'sd0);
        directed(CMD_DISPLAY, 0, 32'sd0);

        grow = 1'b1;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 55 == 54)
                grow = ~grow;
            random_command(grow);
            if (k == 150 || k == 300)
                drain();
            else
                pace();
        end

        drain();
        repeat (10)
            @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
